/* src/lprd_pkg.sv */
// ----------------------------------------------------------------------------
// lprd_pkg
// shared types and constants of the life pattern rle decoder
// ----------------------------------------------------------------------------
package lprd_pkg;

  // default widths of the position and count registers
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned CountBitsDef = 16;

  // width of the result fields on the output port
  localparam int unsigned FieldBits = 16;

  // depth of the token queue between front and back
  localparam int unsigned QueueDepth = 2;

  // characters with a meaning of their own
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharLive    = 8'h6F;  // 'o'
  localparam logic [7:0] CharDead    = 8'h62;  // 'b'
  localparam logic [7:0] CharEol     = 8'h24;  // '$'
  localparam logic [7:0] CharBang    = 8'h21;  // '!'
  localparam logic [7:0] CharLf      = 8'h0A;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharVt      = 8'h0B;
  localparam logic [7:0] CharFf      = 8'h0C;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharSpace   = 8'h20;

  // token classes handed from front to back
  typedef enum logic [2:0] {
    TokDigit   = 3'd0,
    TokLive    = 3'd1,
    TokDead    = 3'd2,
    TokEol     = 3'd3,
    TokBang    = 3'd4,
    TokNewline = 3'd5,
    TokBad     = 3'd6
  } tok_e;

  typedef struct packed {
    tok_e       cls;
    logic [3:0] digit;
  } token_t;

  // result kinds
  typedef enum logic [1:0] {
    KindRun   = 2'd0,
    KindError = 2'd1,
    KindEnd   = 2'd2
  } kind_e;

endpackage

/* src/lprd_front.sv */
// ----------------------------------------------------------------------------
// lprd_front
// classifies incoming characters into tokens, drops plain whitespace
// ----------------------------------------------------------------------------
module lprd_front (
  input  logic [7:0]      char_code_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            q_full_i,
  output logic            q_push_o,
  output lprd_pkg::token_t q_token_o
);
  import lprd_pkg::*;

  logic keep;

  assign in_ready_o = !q_full_i;

  always_comb begin
    q_token_o.cls   = TokBad;
    q_token_o.digit = '0;
    keep            = 1'b1;
    case (char_code_i) inside
      [CharZero:CharNine]: begin
        q_token_o.cls   = TokDigit;
        q_token_o.digit = 4'(char_code_i - CharZero);
      end
      CharLive:  q_token_o.cls = TokLive;
      CharDead:  q_token_o.cls = TokDead;
      CharEol:   q_token_o.cls = TokEol;
      CharBang:  q_token_o.cls = TokBang;
      CharLf:    q_token_o.cls = TokNewline;
      CharTab, CharVt, CharFf, CharCr, CharSpace: keep = 1'b0;
      default:   q_token_o.cls = TokBad;
    endcase
  end

  // whitespace other than line feed changes nothing anywhere
  assign q_push_o = in_valid_i && !q_full_i && keep;

endmodule

/* src/lprd_queue.sv */
// ----------------------------------------------------------------------------
// lprd_queue
// small token fifo between front and back
// ----------------------------------------------------------------------------
module lprd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lprd_pkg::token_t push_token_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lprd_pkg::token_t pop_token_o
);
  import lprd_pkg::*;

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  token_t              mem_q [QueueDepth];
  logic [PtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o      = (cnt_q == CntBits'(QueueDepth));
  assign valid_o     = (cnt_q != '0);
  assign pop_token_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

endmodule

/* src/lprd_back.sv */
// ----------------------------------------------------------------------------
// lprd_back
// executes tokens against the decoder state and holds the output register
// ----------------------------------------------------------------------------
module lprd_back #(
  parameter int unsigned CoordBits = lprd_pkg::CoordBitsDef,
  parameter int unsigned CountBits = lprd_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tok_valid_i,
  input  lprd_pkg::token_t                tok_i,
  output logic                            tok_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      kind_o,
  output logic [lprd_pkg::FieldBits-1:0]  run_x_o,
  output logic [lprd_pkg::FieldBits-1:0]  run_y_o,
  output logic [lprd_pkg::FieldBits-1:0]  run_length_o
);
  import lprd_pkg::*;

  localparam int unsigned SumBits = ((CoordBits > CountBits) ? CoordBits : CountBits) + 1;
  localparam int unsigned MulBits = CountBits + 4;

  logic                 header_q, header_d;
  logic                 error_q, error_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 digits_q, digits_d;
  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;

  logic                 out_valid_q, out_valid_d;
  kind_e                kind_q, kind_d;
  logic [FieldBits-1:0] run_x_q, run_x_d;
  logic [FieldBits-1:0] run_y_q, run_y_d;
  logic [FieldBits-1:0] run_len_q, run_len_d;

  logic                 out_free, step, emit;
  logic [CountBits-1:0] n;
  logic [MulBits-1:0]   acc;
  logic [CountBits-1:0] count_sat;
  logic [SumBits-1:0]   sum_x, sum_y, coord_lim;
  logic [CoordBits-1:0] sat_x, sat_y;
  logic [CoordBits+FieldBits-1:0] x_ext, y_ext;
  logic [CountBits+FieldBits-1:0] n_ext;

  assign out_free  = !out_valid_q || out_ready_i;
  assign step      = tok_valid_i && out_free;
  assign tok_pop_o = step;

  // count taken by a run command, absent count means one
  assign n = digits_q ? count_q : CountBits'(1);

  // count * 10 + digit as two shifts and two adds
  assign acc = (MulBits'(count_q) << 3) + (MulBits'(count_q) << 1) + MulBits'(tok_i.digit);
  assign count_sat = (acc > MulBits'({CountBits{1'b1}})) ? {CountBits{1'b1}}
                                                         : acc[CountBits-1:0];

  // saturating coordinate adds
  assign coord_lim = SumBits'({CoordBits{1'b1}});
  assign sum_x = SumBits'(pos_x_q) + SumBits'(n);
  assign sum_y = SumBits'(pos_y_q) + SumBits'(n);
  assign sat_x = (sum_x > coord_lim) ? {CoordBits{1'b1}} : sum_x[CoordBits-1:0];
  assign sat_y = (sum_y > coord_lim) ? {CoordBits{1'b1}} : sum_y[CoordBits-1:0];

  // fit to the field width
  assign x_ext = {{FieldBits{1'b0}}, pos_x_q};
  assign y_ext = {{FieldBits{1'b0}}, pos_y_q};
  assign n_ext = {{FieldBits{1'b0}}, n};

  always_comb begin
    header_d  = header_q;
    error_d   = error_q;
    count_d   = count_q;
    digits_d  = digits_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    emit      = 1'b0;
    kind_d    = kind_q;
    run_x_d   = '0;
    run_y_d   = '0;
    run_len_d = '0;
    if (step) begin
      if (header_q) begin
        if (tok_i.cls == TokNewline) begin
          header_d = 1'b0;
        end
      end else if (tok_i.cls == TokBang) begin
        emit     = 1'b1;
        kind_d   = KindEnd;
        header_d = 1'b1;
        error_d  = 1'b0;
        count_d  = '0;
        digits_d = 1'b0;
        pos_x_d  = '0;
        pos_y_d  = '0;
      end else if (!error_q) begin
        case (tok_i.cls)
          TokDigit: begin
            count_d  = count_sat;
            digits_d = 1'b1;
          end
          TokLive: begin
            count_d  = '0;
            digits_d = 1'b0;
            if (n != '0) begin
              emit      = 1'b1;
              kind_d    = KindRun;
              run_x_d   = x_ext[FieldBits-1:0];
              run_y_d   = y_ext[FieldBits-1:0];
              run_len_d = n_ext[FieldBits-1:0];
              pos_x_d   = sat_x;
            end
          end
          TokDead: begin
            count_d  = '0;
            digits_d = 1'b0;
            pos_x_d  = sat_x;
          end
          TokEol: begin
            count_d  = '0;
            digits_d = 1'b0;
            pos_y_d  = sat_y;
            pos_x_d  = '0;
          end
          TokNewline: ;
          TokBad: begin
            emit    = 1'b1;
            kind_d  = KindError;
            error_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
    if (step) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= 1'b1;
      error_q     <= 1'b0;
      count_q     <= '0;
      digits_q    <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      header_q    <= header_d;
      error_q     <= error_d;
      count_q     <= count_d;
      digits_q    <= digits_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      kind_q    <= kind_d;
      run_x_q   <= run_x_d;
      run_y_q   <= run_y_d;
      run_len_q <= run_len_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign run_x_o      = run_x_q;
  assign run_y_o      = run_y_q;
  assign run_length_o = run_len_q;

endmodule

/* src/life_pattern_rle_decoder.sv */
// ----------------------------------------------------------------------------
// life_pattern_rle_decoder
// decodes rle pattern text, one character per request, into live cell runs
// ----------------------------------------------------------------------------
// usage
//   input channel: one byte of pattern text per request (char_code_i),
//   in_valid_i / in_ready_o. the header line up to the first line feed is
//   skipped, then digits, 'o', 'b', '$', whitespace and '!' are decoded.
//   output channel: out_valid_o / out_ready_i with kind_o (live run, bad
//   character error, end of pattern) and run_x_o / run_y_o / run_length_o.
//   at most one result per input character; many characters give none.
//   throughput: one character per cycle while the receiver takes results,
//   limited by the token step in the back part (times-ten add plus
//   saturating coordinate add). a character accepted is written into the
//   queue; the back part then takes its token and loads its result into
//   the output register.
//   reset: decoder returns to header mode, position and count cleared,
//   queue and output register empty.
//   receiver stall: the output register holds its result; the back part
//   stops, the two-entry queue fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module life_pattern_rle_decoder #(
  parameter int unsigned CoordBits = lprd_pkg::CoordBitsDef,
  parameter int unsigned CountBits = lprd_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      char_code_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      kind_o,
  output logic [lprd_pkg::FieldBits-1:0]  run_x_o,
  output logic [lprd_pkg::FieldBits-1:0]  run_y_o,
  output logic [lprd_pkg::FieldBits-1:0]  run_length_o
);
  import lprd_pkg::*;

  // front to queue
  logic   q_full, q_push;
  token_t q_in_token;

  // queue to back
  logic   q_valid, q_pop;
  token_t q_out_token;

  // front: classify characters, plain whitespace never enters the queue
  lprd_front u_front (
    .char_code_i (char_code_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_token_o   (q_in_token)
  );

  // queue decouples input acceptance from output stalls
  lprd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_token_i (q_in_token),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_token_o  (q_out_token)
  );

  // back: decoder state, run emission and the output register
  lprd_back #(
    .CoordBits (CoordBits),
    .CountBits (CountBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (q_valid),
    .tok_i        (q_out_token),
    .tok_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .run_x_o      (run_x_o),
    .run_y_o      (run_y_o),
    .run_length_o (run_length_o)
  );

endmodule
